// ===== rtl/arpr_pkg.sv =====
// Shared types, constants and handshake structs for the ARP resolver.
// Used by the datapath, controller and top level; depends on nothing.
package arpr_pkg;

    localparam int CACHE_ENTRIES_DEF   = 16;
    localparam int PENDING_ENTRIES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF     = 8;
    localparam int MAX_RESULTS         = 8;

    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int AGE_W     = 32;
    localparam int HANDLE_W  = 16;
    localparam int ELAPSED_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [MAC_W-1:0] BROADCAST_MAC  = '1;
    localparam logic [AGE_W-1:0] CACHE_LIFE_RST = 32'd30000;
    localparam logic [AGE_W-1:0] REQ_HOLD_RST   = 32'd5000;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_RECV = 2'd1,
        CMD_TICK = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        FK_IPV4  = 2'd0,
        FK_ARP   = 2'd1,
        FK_OTHER = 2'd2
    } frame_kind_t;

    typedef enum logic [1:0] {
        RK_IPV4      = 2'd0,
        RK_ARP_REQ   = 2'd1,
        RK_ARP_REPLY = 2'd2,
        RK_DELIVER   = 2'd3
    } result_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_MAC    = 2'd0,
        CFG_OWN_IP     = 2'd1,
        CFG_CACHE_LIFE = 2'd2,
        CFG_REQ_HOLD   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        SEL_HIT   = 3'd0,
        SEL_REQ   = 3'd1,
        SEL_REPLY = 3'd2,
        SEL_DELIV = 3'd3,
        SEL_FLUSH = 3'd4
    } emit_sel_t;

    typedef struct packed {
        logic      latch;
        logic      scan_clear;
        logic      scan_go;
        logic      scan_pend;
        logic      scan_age;
        logic      learn_wr;
        logic      pend_alloc;
        logic      pend_append;
        logic      fl_next;
        logic      fl_clear;
        logic      emit;
        emit_sel_t sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_send;
        logic is_deliver;
        logic is_arp;
        logic is_tick;
        logic reply;
        logic scan_done;
        logic hit;
        logic cnt_full;
        logic fl_more;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/arpr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module arpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/arpr_datapath.sv =====
// Datapath of the ARP resolver: configuration, input capture, table RAMs,
// scan engine, valid bits and the output register. Uses arpr_pkg and arpr_ram.
module arpr_datapath #(
    parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arpr_pkg::PENDING_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = arpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [arpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          command,
    input  logic [arpr_pkg::IP_W-1:0]           next_hop_ip,
    input  logic [arpr_pkg::HANDLE_W-1:0]       datagram_handle,
    input  logic [arpr_pkg::MAC_W-1:0]          frame_dst_mac,
    input  logic [1:0]                          frame_kind,
    input  logic                                parse_ok,
    input  logic                                arp_is_request,
    input  logic [arpr_pkg::MAC_W-1:0]          arp_sender_mac,
    input  logic [arpr_pkg::IP_W-1:0]           arp_sender_ip,
    input  logic [arpr_pkg::IP_W-1:0]           arp_target_ip,
    input  logic [arpr_pkg::ELAPSED_W-1:0]      elapsed_ms,
    input  arpr_pkg::ctl_cmd_t                  cmd,
    output arpr_pkg::dp_stat_t                  stat,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          result_kind,
    output logic [arpr_pkg::MAC_W-1:0]          dest_mac,
    output logic [arpr_pkg::IP_W-1:0]           target_ip,
    output logic [arpr_pkg::HANDLE_W-1:0]       handle_out,
    output logic                                last
);

    localparam int CW   = $clog2(CACHE_ENTRIES);
    localparam int PW   = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int MAXN = (CACHE_ENTRIES > PENDING_ENTRIES) ? CACHE_ENTRIES : PENDING_ENTRIES;
    localparam int SW   = $clog2(MAXN + 1);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int HD   = PENDING_ENTRIES * QUEUE_DEPTH;
    localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;
    localparam int IPW  = arpr_pkg::IP_W;
    localparam int MW   = arpr_pkg::MAC_W;
    localparam int AW   = arpr_pkg::AGE_W;
    localparam int CRW  = IPW + MW + AW;
    localparam int PRW  = IPW + AW + CNTW;

    logic [MW-1:0]  own_mac_reg;
    logic [IPW-1:0] own_ip_reg;
    logic [AW-1:0]  life_reg;
    logic [AW-1:0]  hold_reg;

    logic [1:0]                       cmd_in_reg;
    logic [IPW-1:0]                   hop_reg;
    logic [arpr_pkg::HANDLE_W-1:0]    handle_reg;
    logic [MW-1:0]                    dst_reg;
    logic [1:0]                       fkind_reg;
    logic                             ok_reg;
    logic                             isreq_reg;
    logic [MW-1:0]                    smac_reg;
    logic [IPW-1:0]                   sip_reg;
    logic [IPW-1:0]                   tip_reg;
    logic [arpr_pkg::ELAPSED_W-1:0]   elapsed_reg;

    logic [SW-1:0]   idx_reg;
    logic            rd_v_reg;
    logic [SW-1:0]   rd_idx_reg;
    logic            hit_reg;
    logic            free_reg;
    logic            maxf_reg;
    logic [SW-1:0]   hit_idx_reg;
    logic [SW-1:0]   free_idx_reg;
    logic [SW-1:0]   max_idx_reg;
    logic [MW-1:0]   hit_mac_reg;
    logic [AW-1:0]   hit_age_reg;
    logic [CNTW-1:0] hit_cnt_reg;
    logic [AW-1:0]   max_age_reg;
    logic [CNTW-1:0] fl_i_reg;

    logic cache_valid_reg [CACHE_ENTRIES];
    logic pend_valid_reg  [PENDING_ENTRIES];

    logic                           out_valid_reg;
    logic [1:0]                     rk_reg;
    logic [MW-1:0]                  dmac_reg;
    logic [IPW-1:0]                 tip_out_reg;
    logic [arpr_pkg::HANDLE_W-1:0]  hout_reg;
    logic                           last_reg;

    logic [CRW-1:0] c_rdata;
    logic [PRW-1:0] p_rdata;
    logic [arpr_pkg::HANDLE_W-1:0] h_rdata;

    logic [CW-1:0]   c_idx;
    logic [PW-1:0]   p_idx;
    logic [IPW-1:0]  c_ip;
    logic [MW-1:0]   c_mac;
    logic [AW-1:0]   c_age;
    logic [IPW-1:0]  p_ip;
    logic [AW-1:0]   p_age;
    logic [CNTW-1:0] p_cnt;
    logic            e_valid;
    logic [IPW-1:0]  e_ip;
    logic [AW-1:0]   e_age;
    logic [AW:0]     age_sum;
    logic [AW-1:0]   new_age;
    logic [AW-1:0]   limit;
    logic [IPW-1:0]  key_ip;
    logic [SW-1:0]   n_lim;
    logic            issue;
    logic            find;
    logic            agew;
    logic            expire;
    logic            match;
    logic [SW-1:0]   slot;
    logic            for_us;
    logic            is_recv;
    logic            out_free;
    logic            cnt_full;
    logic            fl_last;

    logic             c_we;
    logic [CW-1:0]    c_waddr;
    logic [CRW-1:0]   c_wdata;
    logic             p_we;
    logic [PW-1:0]    p_waddr;
    logic [PRW-1:0]   p_wdata;
    logic             h_we;
    logic [HAW-1:0]   h_waddr;
    logic [HAW-1:0]   h_raddr;

    assign c_idx = rd_idx_reg[CW-1:0];
    assign p_idx = rd_idx_reg[PW-1:0];
    assign c_ip  = c_rdata[CRW-1 -: IPW];
    assign c_mac = c_rdata[AW +: MW];
    assign c_age = c_rdata[AW-1:0];
    assign p_ip  = p_rdata[PRW-1 -: IPW];
    assign p_age = p_rdata[CNTW +: AW];
    assign p_cnt = p_rdata[CNTW-1:0];

    assign e_valid = cmd.scan_pend ? pend_valid_reg[p_idx] : cache_valid_reg[c_idx];
    assign e_ip    = cmd.scan_pend ? p_ip : c_ip;
    assign e_age   = cmd.scan_pend ? p_age : c_age;
    assign age_sum = {1'b0, e_age} + (AW + 1)'(elapsed_reg);
    assign new_age = age_sum[AW] ? '1 : age_sum[AW-1:0];
    assign limit   = cmd.scan_pend ? hold_reg : life_reg;
    assign key_ip  = (cmd_in_reg == arpr_pkg::CMD_SEND) ? hop_reg : sip_reg;
    assign n_lim   = cmd.scan_pend ? SW'(PENDING_ENTRIES) : SW'(CACHE_ENTRIES);
    assign issue   = cmd.scan_go && !cmd.scan_clear && (idx_reg != n_lim);
    assign find    = rd_v_reg && !cmd.scan_age && !cmd.scan_clear;
    assign agew    = rd_v_reg && cmd.scan_age && !cmd.scan_clear && e_valid;
    assign expire  = agew && (new_age >= limit);
    assign match   = e_valid && (e_ip == key_ip);
    assign slot    = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : max_idx_reg);

    assign for_us   = (dst_reg == arpr_pkg::BROADCAST_MAC) || (dst_reg == own_mac_reg);
    assign is_recv  = (cmd_in_reg == arpr_pkg::CMD_RECV) && for_us && ok_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign cnt_full = (hit_cnt_reg == CNTW'(QUEUE_DEPTH));
    assign fl_last  = (32'(fl_i_reg) + 32'd1 >= 32'(hit_cnt_reg))
                   || (32'(fl_i_reg) + 32'd1 >= 32'(arpr_pkg::MAX_RESULTS));

    always_comb
    begin
        stat            = '0;
        stat.is_send    = (cmd_in_reg == arpr_pkg::CMD_SEND);
        stat.is_deliver = is_recv && (fkind_reg == arpr_pkg::FK_IPV4);
        stat.is_arp     = is_recv && (fkind_reg == arpr_pkg::FK_ARP);
        stat.is_tick    = (cmd_in_reg == arpr_pkg::CMD_TICK);
        stat.reply      = isreq_reg && (tip_reg == own_ip_reg);
        stat.scan_done  = (idx_reg == n_lim) && !rd_v_reg;
        stat.hit        = hit_reg;
        stat.cnt_full   = cnt_full;
        stat.fl_more    = (32'(fl_i_reg) < 32'(hit_cnt_reg))
                       && (32'(fl_i_reg) < 32'(arpr_pkg::MAX_RESULTS));
        stat.out_free   = out_free;
    end

    assign c_we    = (agew && !cmd.scan_pend) || cmd.learn_wr;
    assign c_waddr = cmd.learn_wr ? slot[CW-1:0] : c_idx;
    assign c_wdata = cmd.learn_wr ? {sip_reg, smac_reg, {AW{1'b0}}} : {c_ip, c_mac, new_age};

    assign p_we = (agew && cmd.scan_pend) || cmd.pend_alloc || cmd.pend_append;

    always_comb
    begin
        if (cmd.pend_alloc)
        begin
            p_waddr = slot[PW-1:0];
            p_wdata = {hop_reg, {AW{1'b0}}, CNTW'(1)};
        end
        else if (cmd.pend_append)
        begin
            p_waddr = hit_idx_reg[PW-1:0];
            p_wdata = {hop_reg, hit_age_reg, hit_cnt_reg + CNTW'(1)};
        end
        else
        begin
            p_waddr = p_idx;
            p_wdata = {p_ip, new_age, p_cnt};
        end
    end

    assign h_we    = cmd.pend_alloc || cmd.pend_append;
    assign h_waddr = cmd.pend_alloc
                   ? HAW'(32'(slot[PW-1:0]) * QUEUE_DEPTH)
                   : HAW'(32'(hit_idx_reg[PW-1:0]) * QUEUE_DEPTH + 32'(hit_cnt_reg));
    assign h_raddr = HAW'(32'(hit_idx_reg[PW-1:0]) * QUEUE_DEPTH + 32'(fl_i_reg));

    arpr_ram #(.WIDTH(CRW), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (idx_reg[CW-1:0]),
        .rdata (c_rdata)
    );

    arpr_ram #(.WIDTH(PRW), .DEPTH(PENDING_ENTRIES)) u_pend_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (idx_reg[PW-1:0]),
        .rdata (p_rdata)
    );

    arpr_ram #(.WIDTH(arpr_pkg::HANDLE_W), .DEPTH(HD)) u_handle_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (handle_reg),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
            life_reg    <= arpr_pkg::CACHE_LIFE_RST;
            hold_reg    <= arpr_pkg::REQ_HOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                arpr_pkg::CFG_OWN_MAC:    own_mac_reg <= cfg_data;
                arpr_pkg::CFG_OWN_IP:     own_ip_reg  <= cfg_data[IPW-1:0];
                arpr_pkg::CFG_CACHE_LIFE: life_reg    <= cfg_data[AW-1:0];
                arpr_pkg::CFG_REQ_HOLD:   hold_reg    <= cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_in_reg  <= command;
            hop_reg     <= next_hop_ip;
            handle_reg  <= datagram_handle;
            dst_reg     <= frame_dst_mac;
            fkind_reg   <= frame_kind;
            ok_reg      <= parse_ok;
            isreq_reg   <= arp_is_request;
            smac_reg    <= arp_sender_mac;
            sip_reg     <= arp_sender_ip;
            tip_reg     <= arp_target_ip;
            elapsed_reg <= elapsed_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            rd_v_reg <= 1'b0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            maxf_reg <= 1'b0;
            fl_i_reg <= '0;
        end
        else if (cmd.scan_clear)
        begin
            idx_reg  <= '0;
            rd_v_reg <= 1'b0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            maxf_reg <= 1'b0;
            fl_i_reg <= '0;
        end
        else
        begin
            rd_v_reg <= issue;
            if (issue)
            begin
                idx_reg <= idx_reg + SW'(1);
            end
            if (find && match)
            begin
                hit_reg <= 1'b1;
            end
            if (find && !e_valid)
            begin
                free_reg <= 1'b1;
            end
            if (find && e_valid)
            begin
                maxf_reg <= 1'b1;
            end
            if (cmd.fl_next)
            begin
                fl_i_reg <= fl_i_reg + CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (find && match && !hit_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_mac_reg <= c_mac;
            hit_age_reg <= p_age;
            hit_cnt_reg <= p_cnt;
        end
        if (find && !e_valid && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (find && e_valid && (!maxf_reg || e_age > max_age_reg))
        begin
            max_idx_reg <= rd_idx_reg;
            max_age_reg <= e_age;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                cache_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < PENDING_ENTRIES; i++)
            begin
                pend_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (expire && !cmd.scan_pend)
            begin
                cache_valid_reg[c_idx] <= 1'b0;
            end
            if (cmd.learn_wr)
            begin
                cache_valid_reg[slot[CW-1:0]] <= 1'b1;
            end
            if (expire && cmd.scan_pend)
            begin
                pend_valid_reg[p_idx] <= 1'b0;
            end
            if (cmd.pend_alloc)
            begin
                pend_valid_reg[slot[PW-1:0]] <= 1'b1;
            end
            if (cmd.fl_clear)
            begin
                pend_valid_reg[hit_idx_reg[PW-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.sel)
                arpr_pkg::SEL_HIT:
                begin
                    rk_reg      <= arpr_pkg::RK_IPV4;
                    dmac_reg    <= hit_mac_reg;
                    tip_out_reg <= '0;
                    hout_reg    <= handle_reg;
                    last_reg    <= 1'b1;
                end
                arpr_pkg::SEL_REQ:
                begin
                    rk_reg      <= arpr_pkg::RK_ARP_REQ;
                    dmac_reg    <= arpr_pkg::BROADCAST_MAC;
                    tip_out_reg <= hop_reg;
                    hout_reg    <= '0;
                    last_reg    <= 1'b1;
                end
                arpr_pkg::SEL_REPLY:
                begin
                    rk_reg      <= arpr_pkg::RK_ARP_REPLY;
                    dmac_reg    <= smac_reg;
                    tip_out_reg <= sip_reg;
                    hout_reg    <= '0;
                    last_reg    <= 1'b1;
                end
                arpr_pkg::SEL_DELIV:
                begin
                    rk_reg      <= arpr_pkg::RK_DELIVER;
                    dmac_reg    <= '0;
                    tip_out_reg <= '0;
                    hout_reg    <= handle_reg;
                    last_reg    <= 1'b1;
                end
                default:
                begin
                    rk_reg      <= arpr_pkg::RK_IPV4;
                    dmac_reg    <= smac_reg;
                    tip_out_reg <= '0;
                    hout_reg    <= h_rdata;
                    last_reg    <= fl_last;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = rk_reg;
    assign dest_mac    = dmac_reg;
    assign target_ip   = tip_out_reg;
    assign handle_out  = hout_reg;
    assign last        = last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("Transaction loaded into a busy output register.");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pend_append |-> !cnt_full)
        else $error("Handle appended to a full queue.");

    a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fl_i_reg) <= 32'(arpr_pkg::MAX_RESULTS))
        else $error("Flush ran past the result limit.");

    a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> $past(cmd.scan_go))
        else $error("Read data marked valid without a scan step.");

endmodule

// ===== rtl/arpr_ctrl.sv =====
// Controller state machine of the ARP resolver; sequences scans, writes and emits.
// Uses arpr_pkg for the command and status structs.
module arpr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  arpr_pkg::dp_stat_t  stat,
    output arpr_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_DISPATCH   = 14'b00000000000010,
        S_SEND_C     = 14'b00000000000100,
        S_SEND_P     = 14'b00000000001000,
        S_EMIT_HIT   = 14'b00000000010000,
        S_EMIT_REQ   = 14'b00000000100000,
        S_EMIT_REPLY = 14'b00000001000000,
        S_EMIT_DELIV = 14'b00000010000000,
        S_LEARN      = 14'b00000100000000,
        S_FL_SCAN    = 14'b00001000000000,
        S_FL_RD      = 14'b00010000000000,
        S_FL_EMIT    = 14'b00100000000000,
        S_TICK_C     = 14'b01000000000000,
        S_TICK_P     = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch      = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_send)
                begin
                    state_next = S_SEND_C;
                end
                else if (stat.is_deliver)
                begin
                    state_next = S_EMIT_DELIV;
                end
                else if (stat.is_arp)
                begin
                    state_next = S_LEARN;
                end
                else if (stat.is_tick)
                begin
                    state_next = S_TICK_C;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEND_C:
            begin
                cmd.scan_go = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.hit)
                    begin
                        state_next = S_EMIT_HIT;
                    end
                    else
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_SEND_P;
                    end
                end
            end
            S_SEND_P:
            begin
                cmd.scan_go   = 1'b1;
                cmd.scan_pend = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.hit)
                    begin
                        cmd.pend_append = !stat.cnt_full;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.pend_alloc = 1'b1;
                        state_next     = S_EMIT_REQ;
                    end
                end
            end
            S_EMIT_HIT:
            begin
                cmd.sel  = arpr_pkg::SEL_HIT;
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_REQ:
            begin
                cmd.sel  = arpr_pkg::SEL_REQ;
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_REPLY:
            begin
                cmd.sel  = arpr_pkg::SEL_REPLY;
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_DELIV:
            begin
                cmd.sel  = arpr_pkg::SEL_DELIV;
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LEARN:
            begin
                cmd.scan_go = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.learn_wr = 1'b1;
                    if (stat.reply)
                    begin
                        state_next = S_EMIT_REPLY;
                    end
                    else
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_FL_SCAN;
                    end
                end
            end
            S_FL_SCAN:
            begin
                cmd.scan_go   = 1'b1;
                cmd.scan_pend = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = stat.hit ? S_FL_RD : S_IDLE;
                end
            end
            S_FL_RD:
            begin
                if (stat.fl_more)
                begin
                    state_next = S_FL_EMIT;
                end
                else
                begin
                    cmd.fl_clear = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FL_EMIT:
            begin
                cmd.sel = arpr_pkg::SEL_FLUSH;
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.fl_next = 1'b1;
                    state_next  = S_FL_RD;
                end
            end
            S_TICK_C:
            begin
                cmd.scan_go  = 1'b1;
                cmd.scan_age = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_TICK_P;
                end
            end
            S_TICK_P:
            begin
                cmd.scan_go   = 1'b1;
                cmd.scan_age  = 1'b1;
                cmd.scan_pend = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DISPATCH))
        else $error("Accepted transaction did not reach dispatch.");

    a_emit_in_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (state_reg != S_IDLE && state_reg != S_DISPATCH))
        else $error("Result emitted outside an emit state.");

endmodule

// ===== rtl/arp_resolver_with_pending_queue.sv =====
// ARP resolver top level: one transaction is processed at a time.
// A send scans the cache and, on a miss, the pending table; a tick ages both tables;
// an ARP flush emits the queued handles one by one through S_FL_RD and S_FL_EMIT.
// Table scans read one entry per cycle through the single read port of each table RAM.
// Asynchronous active-low reset clears all valid bits and control state at once and
// loads default registers.
module arp_resolver_with_pending_queue #(
    parameter int CACHE_ENTRIES   = arpr_pkg::CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arpr_pkg::PENDING_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = arpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [arpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arpr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       command,
    input  logic [arpr_pkg::IP_W-1:0]        next_hop_ip,
    input  logic [arpr_pkg::HANDLE_W-1:0]    datagram_handle,
    input  logic [arpr_pkg::MAC_W-1:0]       frame_dst_mac,
    input  logic [1:0]                       frame_kind,
    input  logic                             parse_ok,
    input  logic                             arp_is_request,
    input  logic [arpr_pkg::MAC_W-1:0]       arp_sender_mac,
    input  logic [arpr_pkg::IP_W-1:0]        arp_sender_ip,
    input  logic [arpr_pkg::IP_W-1:0]        arp_target_ip,
    input  logic [arpr_pkg::ELAPSED_W-1:0]   elapsed_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       result_kind,
    output logic [arpr_pkg::MAC_W-1:0]       dest_mac,
    output logic [arpr_pkg::IP_W-1:0]        target_ip,
    output logic [arpr_pkg::HANDLE_W-1:0]    handle_out,
    output logic                             last
);

    arpr_pkg::ctl_cmd_t cmd;
    arpr_pkg::dp_stat_t stat;

    arpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    arpr_datapath #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .next_hop_ip     (next_hop_ip),
        .datagram_handle (datagram_handle),
        .frame_dst_mac   (frame_dst_mac),
        .frame_kind      (frame_kind),
        .parse_ok        (parse_ok),
        .arp_is_request  (arp_is_request),
        .arp_sender_mac  (arp_sender_mac),
        .arp_sender_ip   (arp_sender_ip),
        .arp_target_ip   (arp_target_ip),
        .elapsed_ms      (elapsed_ms),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .dest_mac        (dest_mac),
        .target_ip       (target_ip),
        .handle_out      (handle_out),
        .last            (last)
    );

endmodule
